@@ hdl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/ssc_pkg.sv @@
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types, command codes and glyph lookup for the scan controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssc_pkg;

    localparam int DIGITS = 4;

    typedef enum logic [3:0] {
        CMD_TICK      = 4'd0,
        CMD_WR_ABS    = 4'd1,
        CMD_WR_DIG    = 4'd2,
        CMD_SETPOS    = 4'd3,
        CMD_SWIPE     = 4'd4,
        CMD_BOUNCE    = 4'd5,
        CMD_BLINK_DIG = 4'd6,
        CMD_BLINK_SCR = 4'd7,
        CMD_ERASE     = 4'd8,
        CMD_CUR_ON    = 4'd9,
        CMD_CUR_OFF   = 4'd10,
        CMD_CUR_INC   = 4'd11,
        CMD_CUR_DEC   = 4'd12
    } t_cmd;

    // controller -> datapath
    typedef struct packed {
        logic latch;
        logic exec;
        logic tick_wr;
        logic sw_glyph;
        logic sw_blink;
        logic b4_wr;
        logic cnt_clr;
        logic load_out;
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [3:0] cmd;
        logic       b4_ok;
        logic       cursor_on;
        logic       cnt_last;
        logic       cnt_last4;
    } t_ctl_sts;

    localparam logic [7:0] DIGIT_GLYPHS [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};
    localparam logic [7:0] LETTER_GLYPHS [26] = '{
        8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76, 8'h30, 8'h1E,
        8'h75, 8'h38, 8'h00, 8'h54, 8'h3F, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
        8'h3E, 8'h00, 8'h00, 8'h00, 8'h6E, 8'h00};
    localparam logic [7:0] SEGMENT_GLYPHS [9] = '{
        8'h00, 8'h01, 8'h02, 8'h04, 8'h10, 8'h20, 8'h40, 8'h18, 8'h08};

    function automatic logic [7:0] to_glyph(input logic [7:0] c);
        logic [7:0] g;
        g = 8'h00;
        if (c <= 8'd9) begin
            g = DIGIT_GLYPHS[c[3:0]];
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            g = LETTER_GLYPHS[5'(c - 8'h41)];
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            g = LETTER_GLYPHS[5'(c - 8'h61)];
        end else if (c >= 8'd247) begin
            g = SEGMENT_GLYPHS[4'(c - 8'd247)];
        end
        return g;
    endfunction

endpackage

@@ hdl/ssc_datapath.sv @@
// ----------------------------------------------------------------------------
// ssc_datapath
// Pattern and blink stores, window and scan registers, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssc_datapath
    import ssc_pkg::*;
#(
    parameter int STORE_DEPTH = 64,
    parameter int BLINK_TICKS = 60,
    parameter int SCAN_TICKS  = 5,
    parameter int MOVE_TICKS  = 700
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctl_cmd          i_ctl,
    output t_ctl_sts          o_sts,
    input  logic [3:0]        i_cmd,
    input  logic [5:0]        i_slot_index,
    input  logic [7:0]        i_char_code,
    input  logic signed [6:0] i_step_count,
    input  logic              i_on_flag,
    input  logic              i_cfg_valid,
    input  logic [2:0]        i_cfg_data,
    output logic [7:0]        o_segments,
    output logic [1:0]        o_digit_select,
    output logic              o_accepted
);

    localparam int AW      = $clog2(STORE_DEPTH);
    localparam int WIN_MAX = STORE_DEPTH - DIGITS;
    localparam logic [5:0] BT = 6'(BLINK_TICKS);
    localparam logic [9:0] MT = 10'(MOVE_TICKS);
    localparam logic [2:0] ST = 3'(SCAN_TICKS);

    logic [7:0] r_gmem [STORE_DEPTH];
    logic [7:0] r_bmem [STORE_DEPTH];
    logic [7:0] r_gq, r_bq;

    logic [3:0]        r_cmd;
    logic [5:0]        r_idx;
    logic [7:0]        r_code;
    logic signed [6:0] r_steps;
    logic              r_flag;

    logic [2:0]        r_bright;
    logic [AW-1:0]     r_ws, n_ws;
    logic [1:0]        r_scan, n_scan;
    logic [2:0]        r_wt, n_wt;
    logic [3:0]        r_duty, n_duty;
    logic signed [7:0] r_moves, n_moves;
    logic [9:0]        r_mt, n_mt;
    logic              r_bounce, n_bounce;
    logic signed [7:0] r_span, n_span;
    logic              r_cursor, n_cursor;
    logic [1:0]        r_cdig, n_cdig;
    logic [1:0]        r_b4_digit, n_b4_digit;
    logic              r_b4_clear, n_b4_clear;
    logic              r_sw_en, n_sw_en;
    logic [AW-1:0]     r_cnt;
    logic [7:0]        r_seg, n_seg;
    logic [1:0]        r_dig, n_dig;
    logic              r_ok, n_ok;

    logic [AW-1:0] s_scan, s_idx, s_cnt;
    logic          g_we, b_we;
    logic [AW-1:0] g_addr, b_addr;
    logic [7:0]    g_data, b_data;
    logic          b4_ok;

    assign s_scan = r_ws + AW'(r_scan);
    assign s_idx  = r_ws + AW'(r_idx[1:0]);
    assign s_cnt  = r_ws + AW'(r_cnt[1:0]);
    assign b4_ok  = r_flag || (r_idx < 6'(DIGITS));

    assign o_sts = '{cmd: r_cmd, b4_ok: b4_ok, cursor_on: r_cursor,
                     cnt_last: (r_cnt == AW'(STORE_DEPTH - 1)),
                     cnt_last4: (r_cnt[1:0] == 2'd3)};

    always_comb begin
        int         t;
        logic       ph;
        logic [5:0] tm;
        logic [9:0] mt;
        logic       fwd;
        logic signed [7:0] nm;
        logic [2:0] wt;
        n_ws = r_ws; n_scan = r_scan; n_wt = r_wt; n_duty = r_duty;
        n_moves = r_moves; n_mt = r_mt; n_bounce = r_bounce; n_span = r_span;
        n_cursor = r_cursor; n_cdig = r_cdig; n_b4_digit = r_b4_digit;
        n_b4_clear = r_b4_clear; n_sw_en = r_sw_en;
        n_seg = r_seg; n_dig = r_dig; n_ok = r_ok;
        g_we = 1'b0; g_addr = r_cnt; g_data = 8'h00;
        b_we = 1'b0; b_addr = r_cnt; b_data = 8'h00;
        t = 0; ph = 1'b0; tm = 6'd0; mt = 10'd0; fwd = 1'b0; nm = 8'sd0; wt = 3'd0;

        if (i_ctl.exec) begin
            n_seg = 8'h00;
            n_dig = 2'd0;
            n_ok  = 1'b1;
            case (t_cmd'(r_cmd))
                CMD_TICK: begin
                end
                CMD_WR_ABS: begin
                    if (int'(r_idx) < STORE_DEPTH) begin
                        n_bounce = 1'b0;
                        g_we = 1'b1; g_addr = AW'(r_idx); g_data = to_glyph(r_code);
                    end else begin
                        n_ok = 1'b0;
                    end
                end
                CMD_WR_DIG: begin
                    if (r_idx < 6'(DIGITS)) begin
                        g_we = 1'b1; g_addr = s_idx; g_data = to_glyph(r_code);
                    end else begin
                        n_ok = 1'b0;
                    end
                end
                CMD_SETPOS: begin
                    if (int'(r_idx) <= WIN_MAX) begin
                        n_moves = 8'sd0;
                        n_ws = AW'(r_idx);
                    end else begin
                        n_ok = 1'b0;
                    end
                end
                CMD_SWIPE, CMD_BOUNCE: begin
                    t = int'(r_ws) + int'(r_steps);
                    if (t < 0 || t > WIN_MAX) begin
                        n_ok = 1'b0;
                    end else begin
                        n_bounce = (r_cmd == CMD_BOUNCE);
                        n_moves = {r_steps[6], r_steps};
                        n_mt = MT;
                        if (r_cmd == CMD_BOUNCE) n_span = {r_steps[6], r_steps};
                    end
                end
                CMD_BLINK_DIG: begin
                    n_b4_digit = r_idx[1:0];
                    n_b4_clear = r_flag;
                    if (!b4_ok) n_ok = 1'b0;
                end
                CMD_BLINK_SCR: n_sw_en = r_flag;
                CMD_ERASE: n_bounce = 1'b0;
                CMD_CUR_ON: begin
                    if (!r_cursor) begin
                        n_bounce = 1'b0; n_cursor = 1'b1; n_cdig = 2'd0;
                        n_b4_digit = 2'd0; n_b4_clear = 1'b0;
                    end
                end
                CMD_CUR_OFF: begin
                    if (r_cursor) begin
                        n_cursor = 1'b0; n_cdig = 2'd0; n_sw_en = 1'b0;
                    end
                end
                CMD_CUR_INC: begin
                    n_b4_clear = 1'b0;
                    n_b4_digit = r_cdig;
                    if (r_cursor) begin
                        if (r_cdig == 2'd3) begin
                            if (int'(r_ws) < WIN_MAX) n_ws = r_ws + AW'(1);
                        end else begin
                            n_cdig = r_cdig + 2'd1;
                            n_b4_digit = r_cdig + 2'd1;
                        end
                    end
                end
                CMD_CUR_DEC: begin
                    n_b4_clear = 1'b0;
                    n_b4_digit = r_cdig;
                    if (r_cursor) begin
                        if (r_cdig == 2'd0) begin
                            if (r_ws != '0) n_ws = r_ws - AW'(1);
                        end else begin
                            n_cdig = r_cdig - 2'd1;
                            n_b4_digit = r_cdig - 2'd1;
                        end
                    end
                end
                default: n_ok = 1'b0;
            endcase
        end

        if (i_ctl.tick_wr) begin
            ph = r_bq[6];
            tm = r_bq[5:0];
            n_seg = (ph && r_duty != 4'd0) ? r_gq : 8'h00;
            n_dig = r_scan;
            // run down the shown entry's blink timer
            if (r_bq[7]) begin
                tm = tm - 6'd1;
                if (tm == 6'd0) begin
                    tm = BT;
                    ph = ~ph;
                end
                b_we = 1'b1; b_addr = s_scan; b_data = {1'b1, ph, tm};
            end
            if (r_moves != 8'sd0) begin
                mt = r_mt - 10'd1;
                n_mt = mt;
                if (mt == 10'd0) begin
                    fwd = !r_moves[7];
                    t = int'(r_ws) + (fwd ? 1 : -1);
                    if (t >= 0 && t <= WIN_MAX) n_ws = AW'(t);
                    nm = fwd ? r_moves - 8'sd1 : r_moves + 8'sd1;
                    n_moves = nm;
                    if (nm != 8'sd0) begin
                        n_mt = MT;
                    end else if (r_bounce) begin
                        n_span = -r_span;
                        n_moves = -r_span;
                        n_mt = MT;
                    end
                end
            end
            n_duty = (r_duty != 4'd0) ? r_duty - 4'd1 : r_duty;
            wt = r_wt - 3'd1;
            n_wt = wt;
            if (wt == 3'd0) begin
                n_scan = r_scan + 2'd1;
                n_wt = ST;
                n_duty = {1'b0, r_bright};
            end
        end

        if (i_ctl.sw_glyph) begin
            g_we = 1'b1; g_addr = r_cnt; g_data = 8'h00;
        end
        if (i_ctl.sw_blink) begin
            b_we = 1'b1; b_addr = r_cnt; b_data = {r_sw_en, 1'b1, BT};
        end
        if (i_ctl.b4_wr) begin
            b_we = 1'b1; b_addr = s_cnt;
            b_data = {!r_b4_clear && (r_cnt[1:0] == r_b4_digit), 1'b1, BT};
        end
    end

    always_ff @(posedge i_clk) begin
        if (g_we) r_gmem[g_addr] <= g_data;
        if (b_we) r_bmem[b_addr] <= b_data;
        r_gq <= r_gmem[s_scan];
        r_bq <= r_bmem[s_scan];
        if (i_ctl.latch) begin
            r_cmd <= i_cmd; r_idx <= i_slot_index; r_code <= i_char_code;
            r_steps <= i_step_count; r_flag <= i_on_flag;
        end
        r_seg <= n_seg; r_dig <= n_dig; r_ok <= n_ok;
        if (i_ctl.load_out) begin
            o_segments <= r_seg; o_digit_select <= r_dig; o_accepted <= r_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= 3'd5; r_ws <= '0; r_scan <= 2'd0; r_wt <= ST; r_duty <= 4'd5;
            r_moves <= 8'sd0; r_mt <= 10'd0; r_bounce <= 1'b0; r_span <= 8'sd0;
            r_cursor <= 1'b0; r_cdig <= 2'd0; r_b4_digit <= 2'd0; r_b4_clear <= 1'b0;
            r_sw_en <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_cfg_valid) r_bright <= i_cfg_data;
            r_ws <= n_ws; r_scan <= n_scan; r_wt <= n_wt; r_duty <= n_duty;
            r_moves <= n_moves; r_mt <= n_mt; r_bounce <= n_bounce; r_span <= n_span;
            r_cursor <= n_cursor; r_cdig <= n_cdig; r_b4_digit <= n_b4_digit;
            r_b4_clear <= n_b4_clear; r_sw_en <= n_sw_en;
            if (i_ctl.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_ctl.sw_glyph || i_ctl.sw_blink || i_ctl.b4_wr) begin
                r_cnt <= (r_cnt == AW'(STORE_DEPTH - 1)) ? '0 : r_cnt + AW'(1);
            end
        end
    end

endmodule

@@ hdl/ssc_controller.sv @@
// ----------------------------------------------------------------------------
// ssc_controller
// Sequences each command through execute, a tick, sweep or blink phase where needed, and finish.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssc_controller
    import ssc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_ctl_cmd o_ctl,
    input  t_ctl_sts i_sts
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_TICK, S_SWEEP, S_BLINK4, S_FINISH
    } t_state;

    t_state r_state;
    logic   r_swg, r_swb, r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_ctl = '0;
        o_ctl.latch    = (r_state == S_IDLE) && i_in_valid;
        o_ctl.exec     = (r_state == S_EXEC);
        o_ctl.cnt_clr  = (r_state == S_EXEC);
        o_ctl.tick_wr  = (r_state == S_TICK);
        o_ctl.sw_glyph = (r_state == S_SWEEP || r_state == S_CLEAR) && r_swg;
        o_ctl.sw_blink = (r_state == S_SWEEP || r_state == S_CLEAR) && r_swb;
        o_ctl.b4_wr    = (r_state == S_BLINK4);
        o_ctl.load_out = (r_state == S_FINISH) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_swg       <= 1'b1;
            r_swb       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ctl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: if (i_sts.cnt_last) r_state <= S_IDLE;
                S_IDLE: if (i_in_valid) r_state <= S_EXEC;
                S_EXEC: begin
                    r_swg   <= 1'b0;
                    r_swb   <= 1'b0;
                    r_state <= S_FINISH;
                    case (t_cmd'(i_sts.cmd))
                        CMD_TICK: r_state <= S_TICK;
                        CMD_BLINK_DIG: if (i_sts.b4_ok) r_state <= S_BLINK4;
                        CMD_BLINK_SCR: begin
                            r_swb <= 1'b1; r_state <= S_SWEEP;
                        end
                        CMD_ERASE: begin
                            r_swg <= 1'b1; r_state <= S_SWEEP;
                        end
                        CMD_CUR_ON: if (!i_sts.cursor_on) r_state <= S_BLINK4;
                        CMD_CUR_OFF: begin
                            if (i_sts.cursor_on) begin
                                r_swb <= 1'b1; r_state <= S_SWEEP;
                            end
                        end
                        CMD_CUR_INC, CMD_CUR_DEC: if (i_sts.cursor_on) r_state <= S_BLINK4;
                        default: r_state <= S_FINISH;
                    endcase
                end
                S_TICK: r_state <= S_FINISH;
                S_SWEEP: if (i_sts.cnt_last) r_state <= S_FINISH;
                S_BLINK4: if (i_sts.cnt_last4) r_state <= S_FINISH;
                S_FINISH: if (out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ hdl/seven_segment_scan_controller_core.sv @@
// ----------------------------------------------------------------------------
// seven_segment_scan_controller_core
// Four-digit multiplexed seven-segment scan controller, top level.
// ----------------------------------------------------------------------------
// channel  | handshake                 | payload
// input    | i_in_valid / o_in_stall   | i_cmd i_slot_index i_char_code i_step_count i_on_flag
// result   | o_out_valid / i_out_stall | o_segments o_digit_select o_accepted
// config   | i_cfg_valid / o_cfg_ready | i_cfg_data (bright_level)
//
// A tick passes through execute, tick and finish states from accept to result;
// simple commands through execute and finish; blink digit and cursor commands
// add a four-entry window sweep; erase, blink screen and cursor off a whole-store sweep.
// After reset a clearing pass over every store entry runs before any item is taken.
// One item is in work at a time; a new one is taken while a result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module seven_segment_scan_controller_core
    import ssc_pkg::*;
#(
    parameter int STORE_DEPTH = 64,
    parameter int BLINK_TICKS = 60,
    parameter int SCAN_TICKS  = 5,
    parameter int MOVE_TICKS  = 700
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [3:0]        i_cmd,
    input  logic [5:0]        i_slot_index,
    input  logic [7:0]        i_char_code,
    input  logic signed [6:0] i_step_count,
    input  logic              i_on_flag,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_segments,
    output logic [1:0]        o_digit_select,
    output logic              o_accepted,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_data
);

    t_ctl_cmd ctl;
    t_ctl_sts sts;

    assign o_cfg_ready = 1'b1;

    ssc_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_ctl       (ctl),
        .i_sts       (sts)
    );

    ssc_datapath #(
        .STORE_DEPTH (STORE_DEPTH),
        .BLINK_TICKS (BLINK_TICKS),
        .SCAN_TICKS  (SCAN_TICKS),
        .MOVE_TICKS  (MOVE_TICKS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_cmd          (i_cmd),
        .i_slot_index   (i_slot_index),
        .i_char_code    (i_char_code),
        .i_step_count   (i_step_count),
        .i_on_flag      (i_on_flag),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_segments     (o_segments),
        .o_digit_select (o_digit_select),
        .o_accepted     (o_accepted)
    );

endmodule

@@ hdl/ssc_checker.sv @@
// ----------------------------------------------------------------------------
// ssc_checker
// Port-level checks on the scan controller, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [7:0]        o_segments,
    input logic [1:0]        o_digit_select,
    input logic              o_accepted,
    input logic              o_cfg_ready
);

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid, "result dropped while stalled")
    `ASSERT_CLK(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall |=> $stable(o_segments), "stalled segments changed")
    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall, "second beat taken while busy")
    `ASSERT_CLK(a_tick_ok, i_clk, i_rst_n, o_out_valid && (o_segments != 8'h00 || o_digit_select != 2'd0) |-> o_accepted, "driven digit without accepted flag")
    `ASSERT_ALWAYS(a_cfg_ready, i_clk, o_cfg_ready, "config port not ready")

endmodule

bind seven_segment_scan_controller_core ssc_checker u_chk (.*);

@@ tb/ssc_scoreboard.sv @@
// ----------------------------------------------------------------------------
// ssc_scoreboard
// Watches the command, result and brightness channels of the scan controller,
// predicts every result beat from its own copy of the display state and
// compares each result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssc_scoreboard
    import ssc_pkg::*;
#(
    parameter int STORE_DEPTH = 64,
    parameter int BLINK_TICKS = 60,
    parameter int SCAN_TICKS  = 5,
    parameter int MOVE_TICKS  = 700
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [3:0]        i_cmd,
    input  logic [5:0]        i_slot_index,
    input  logic [7:0]        i_char_code,
    input  logic signed [6:0] i_step_count,
    input  logic              i_on_flag,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [7:0]        i_segments,
    input  logic [1:0]        i_digit_select,
    input  logic              i_accepted,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [2:0]        i_cfg_data,
    output int                o_errors,
    output int                o_pending,
    output int                o_results,
    output int                o_lit
);

    localparam int WIN_MAX = STORE_DEPTH - DIGITS;

    typedef struct packed {
        logic [7:0] segments;
        logic [1:0] digit_select;
        logic       accepted;
    } t_frame;

    localparam logic [7:0] NUM_SEGS [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};
    localparam logic [7:0] ALPHA_SEGS [26] = '{
        8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76, 8'h30, 8'h1E,
        8'h75, 8'h38, 8'h00, 8'h54, 8'h3F, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
        8'h3E, 8'h00, 8'h00, 8'h00, 8'h6E, 8'h00};
    localparam logic [7:0] BAR_SEGS [9] = '{
        8'h00, 8'h01, 8'h02, 8'h04, 8'h10, 8'h20, 8'h40, 8'h18, 8'h08};

    // display state
    logic [2:0] bright;
    logic [7:0] glyphs      [STORE_DEPTH];
    logic       blinking    [STORE_DEPTH];
    logic       shown_phase [STORE_DEPTH];
    logic [5:0] blink_cnt   [STORE_DEPTH];
    int         win_start;
    logic [1:0] scan_pos;
    logic [2:0] scan_left;
    logic [3:0] duty;
    int         steps_left;
    logic [9:0] step_timer;
    logic       bouncing;
    int         bounce_width;
    logic       cursor_active;
    int         cur_digit;

    t_frame frames_due[$];

    function automatic logic [7:0] segs_of(logic [7:0] c);
        if (c <= 8'd9) return NUM_SEGS[c[3:0]];
        if (c >= "A" && c <= "Z") return ALPHA_SEGS[5'(c - "A")];
        if (c >= "a" && c <= "z") return ALPHA_SEGS[5'(c - "a")];
        if (c >= 8'd247) return BAR_SEGS[4'(c - 8'd247)];
        return 8'h00;
    endfunction

    function automatic int entry_of(int d);
        return (win_start + d) % STORE_DEPTH;
    endfunction

    function automatic logic focus_blink(int d, logic clear);
        if (!clear && d >= DIGITS) return 1'b0;
        for (int k = 0; k < DIGITS; k++) begin
            blinking[entry_of(k)]    = 1'b0;
            blink_cnt[entry_of(k)]   = 6'(BLINK_TICKS);
            shown_phase[entry_of(k)] = 1'b1;
        end
        if (!clear) blinking[entry_of(d)] = 1'b1;
        return 1'b1;
    endfunction

    function automatic void blink_all(logic en);
        for (int k = 0; k < STORE_DEPTH; k++) begin
            blinking[k]    = en;
            blink_cnt[k]   = 6'(BLINK_TICKS);
            shown_phase[k] = 1'b1;
        end
    endfunction

    function automatic logic begin_scroll(int n);
        if (win_start + n < 0 || win_start + n > WIN_MAX) return 1'b0;
        bouncing   = 1'b0;
        steps_left = n;
        step_timer = 10'(MOVE_TICKS);
        return 1'b1;
    endfunction

    function automatic void clear_display();
        bright = 3'd5;
        for (int k = 0; k < STORE_DEPTH; k++) begin
            glyphs[k] = '0; blinking[k] = 0; shown_phase[k] = 1; blink_cnt[k] = '0;
        end
        win_start = 0; scan_pos = '0; scan_left = 3'(SCAN_TICKS); duty = 4'd5;
        steps_left = 0; step_timer = '0; bouncing = 0; bounce_width = 0;
        cursor_active = 0; cur_digit = 0;
    endfunction

    function automatic t_frame next_frame(logic [3:0] c, logic [5:0] idx, logic [7:0] code,
                                          logic signed [6:0] st, logic fl);
        t_frame r;
        int     s;
        int     dir;
        int     n;
        r = '0;
        r.accepted = 1'b1;
        n = st;
        case (c)
            CMD_TICK: begin
                s = entry_of(scan_pos);
                r.segments = (shown_phase[s] && duty > 0) ? glyphs[s] : 8'h00;
                r.digit_select = scan_pos;
                if (blinking[s]) begin
                    blink_cnt[s] = blink_cnt[s] - 6'd1;
                    if (blink_cnt[s] == 0) begin
                        blink_cnt[s] = 6'(BLINK_TICKS);
                        shown_phase[s] = ~shown_phase[s];
                    end
                end
                if (steps_left != 0) begin
                    step_timer = step_timer - 10'd1;
                    if (step_timer == 0) begin
                        dir = steps_left > 0 ? 1 : -1;
                        // a step past the bound still counts
                        if (win_start + dir >= 0 && win_start + dir <= WIN_MAX)
                            win_start += dir;
                        steps_left -= dir;
                        if (steps_left != 0) begin
                            step_timer = 10'(MOVE_TICKS);
                        end else if (bouncing) begin
                            bounce_width = -bounce_width;
                            steps_left   = bounce_width;
                            step_timer   = 10'(MOVE_TICKS);
                        end
                    end
                end
                if (duty > 0) duty--;
                scan_left = scan_left - 3'd1;
                if (scan_left == 0) begin
                    scan_pos  = scan_pos + 2'd1;
                    scan_left = 3'(SCAN_TICKS);
                    duty      = {1'b0, bright};
                end
            end
            CMD_WR_ABS: begin
                if (idx < STORE_DEPTH) begin
                    bouncing = 1'b0;
                    glyphs[idx] = segs_of(code);
                end else begin
                    r.accepted = 1'b0;
                end
            end
            CMD_WR_DIG: begin
                if (idx < DIGITS) glyphs[entry_of(idx)] = segs_of(code);
                else r.accepted = 1'b0;
            end
            CMD_SETPOS: begin
                if (idx <= WIN_MAX) begin
                    steps_left = 0;
                    win_start  = idx;
                end else begin
                    r.accepted = 1'b0;
                end
            end
            CMD_SWIPE: r.accepted = begin_scroll(n);
            CMD_BOUNCE: begin
                r.accepted = begin_scroll(n);
                if (r.accepted) begin
                    bouncing     = 1'b1;
                    bounce_width = n;
                end
            end
            CMD_BLINK_DIG: r.accepted = focus_blink(idx, fl);
            CMD_BLINK_SCR: blink_all(fl);
            CMD_ERASE: begin
                bouncing = 1'b0;
                for (int k = 0; k < STORE_DEPTH; k++) glyphs[k] = '0;
            end
            CMD_CUR_ON: begin
                if (!cursor_active) begin
                    bouncing = 1'b0;
                    cursor_active = 1'b1;
                    cur_digit = 0;
                    void'(focus_blink(0, 1'b0));
                end
            end
            CMD_CUR_OFF: begin
                if (cursor_active) begin
                    cursor_active = 1'b0;
                    cur_digit = 0;
                    blink_all(1'b0);
                end
            end
            CMD_CUR_INC: begin
                if (cursor_active) begin
                    // hold the window at its upper bound
                    if (cur_digit >= DIGITS - 1) begin
                        if (win_start < WIN_MAX) win_start++;
                    end else begin
                        cur_digit++;
                    end
                    void'(focus_blink(cur_digit, 1'b0));
                end
            end
            CMD_CUR_DEC: begin
                if (cursor_active) begin
                    if (cur_digit == 0) begin
                        if (win_start > 0) win_start--;
                    end else begin
                        cur_digit--;
                    end
                    void'(focus_blink(cur_digit, 1'b0));
                end
            end
            default: r.accepted = 1'b0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        o_errors++;
    endtask

    initial begin
        o_errors  = 0;
        o_results = 0;
        o_lit     = 0;
        clear_display();
    end

    assign o_pending = frames_due.size();

    always @(posedge i_clk) begin
        t_frame want;
        if (!i_rst_n) begin
            clear_display();
            frames_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) bright = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                frames_due.push_back(next_frame(i_cmd, i_slot_index, i_char_code,
                                                i_step_count, i_on_flag));
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (i_segments != 0) o_lit++;
                if (frames_due.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = frames_due.pop_front();
                    if (i_segments !== want.segments)
                        report_mismatch($sformatf("segments %h, expected %h",
                                                  i_segments, want.segments));
                    if (i_digit_select !== want.digit_select)
                        report_mismatch($sformatf("digit_select %0d, expected %0d",
                                                  i_digit_select, want.digit_select));
                    if (i_accepted !== want.accepted)
                        report_mismatch($sformatf("accepted %b, expected %b",
                                                  i_accepted, want.accepted));
                end
            end
        end
    end

endmodule

@@ tb/seven_segment_scan_controller_core_tb.sv @@
// ----------------------------------------------------------------------------
// seven_segment_scan_controller_core_tb
// Drives directed and random display commands into the scan controller under
// changing brightness levels and back-pressure; the scoreboard checks results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module seven_segment_scan_controller_core_tb;
    import ssc_pkg::*;

    localparam int  CYCLE_LIMIT = 1_000_000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [3:0]        i_cmd;
    logic [5:0]        i_slot_index;
    logic [7:0]        i_char_code;
    logic signed [6:0] i_step_count;
    logic              i_on_flag;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [7:0]        o_segments;
    logic [1:0]        o_digit_select;
    logic              o_accepted;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [2:0]        i_cfg_data;

    int errors;
    int pending;
    int results;
    int lit;
    int send_idle_pct;
    int recv_idle_pct;
    int cycles;

    seven_segment_scan_controller_core uut (.*);

    ssc_scoreboard scoreboard (
        .i_clk, .i_rst_n, .i_in_valid,
        .i_in_stall(o_in_stall),
        .i_cmd, .i_slot_index, .i_char_code, .i_step_count, .i_on_flag,
        .i_out_valid(o_out_valid),
        .i_out_stall,
        .i_segments(o_segments),
        .i_digit_select(o_digit_select),
        .i_accepted(o_accepted),
        .i_cfg_valid,
        .i_cfg_ready(o_cfg_ready),
        .i_cfg_data,
        .o_errors(errors), .o_pending(pending), .o_results(results), .o_lit(lit)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("seven_segment_scan_controller_core_tb: errors");
                $finish;
            end
        end
    end

    // result-side back-pressure
    always @(posedge i_clk) i_out_stall <= ($urandom_range(99) < recv_idle_pct);

    task automatic send_cmd(input logic [3:0] c, input logic [5:0] idx, input logic [7:0] code,
                            input logic signed [6:0] st, input logic fl);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= c;
        i_slot_index <= idx;
        i_char_code  <= code;
        i_step_count <= st;
        i_on_flag    <= fl;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        // let a store sweep finish
        repeat (80) @(posedge i_clk);
    endtask

    task automatic set_brightness(input logic [2:0] level);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= level;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(3))
            0: return 8'($urandom_range(9));
            1: return 8'($urandom_range("A", "Z"));
            2: return 8'($urandom_range(247, 255));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_random();
        int         r;
        logic [5:0] idx;
        logic [6:0] st;
        logic [7:0] code;
        logic       fl;
        r    = $urandom_range(99);
        idx  = 6'($urandom);
        st   = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(6) - 3);
        code = pick_char();
        fl   = 1'($urandom);
        if (r < 60)      send_cmd(CMD_TICK, idx, code, st, fl);
        else if (r < 66) send_cmd(CMD_WR_ABS, idx, code, st, fl);
        else if (r < 72) send_cmd(CMD_WR_DIG, ($urandom_range(4) != 0) ? 6'($urandom_range(3))
                                                                        : idx, code, st, fl);
        else if (r < 75) send_cmd(CMD_SETPOS, idx, code, st, fl);
        else if (r < 78) send_cmd(CMD_SWIPE, idx, code, st, fl);
        else if (r < 80) send_cmd(CMD_BOUNCE, idx, code, st, fl);
        else if (r < 83) send_cmd(CMD_BLINK_DIG, ($urandom_range(2) != 0) ? 6'($urandom_range(3))
                                                                         : idx, code, st, fl);
        else if (r < 84) send_cmd(CMD_BLINK_SCR, idx, code, st, fl);
        else if (r < 85) send_cmd(CMD_ERASE, idx, code, st, fl);
        else if (r < 96) send_cmd(4'($urandom_range(CMD_CUR_ON, CMD_CUR_DEC)), idx, code, st, fl);
        else             send_cmd(4'($urandom), idx, code, st, fl);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_cmd         = CMD_TICK;
        i_slot_index  = '0;
        i_char_code   = '0;
        i_step_count  = '0;
        i_on_flag     = 1'b0;
        i_out_stall   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_brightness(3'd5);

        // directed: edges of every field, rejects and saturation
        send_cmd(CMD_TICK, 6'd0, 8'd0, 7'sd0, 1'b0);
        send_cmd(CMD_WR_ABS, 6'd63, 8'd255, 7'sd0, 1'b1);
        send_cmd(CMD_WR_ABS, 6'd0, "A", -7'sd1, 1'b0);
        send_cmd(CMD_WR_DIG, 6'd3, "z", 7'sd0, 1'b0);
        send_cmd(CMD_WR_DIG, 6'd1, 8'd200, 7'sd0, 1'b0);
        send_cmd(CMD_WR_DIG, 6'd4, "8", 7'sd0, 1'b0);
        send_cmd(CMD_TICK, 6'd63, 8'd255, -7'sd64, 1'b1);
        send_cmd(CMD_SETPOS, 6'd61, 8'd0, 7'sd0, 1'b0);
        send_cmd(CMD_SETPOS, 6'd60, 8'd0, 7'sd0, 1'b0);
        send_cmd(CMD_BOUNCE, 6'd0, 8'd0, 7'sd1, 1'b0);
        send_cmd(CMD_SWIPE, 6'd0, 8'd0, -7'sd60, 1'b0);
        send_cmd(CMD_SETPOS, 6'd0, 8'd0, 7'sd0, 1'b0);
        send_cmd(CMD_SWIPE, 6'd0, 8'd0, -7'sd1, 1'b0);
        send_cmd(CMD_SWIPE, 6'd0, 8'd0, 7'sd63, 1'b0);
        send_cmd(CMD_BOUNCE, 6'd0, 8'd0, 7'sd2, 1'b0);
        send_cmd(CMD_BLINK_DIG, 6'd5, 8'd0, 7'sd0, 1'b0);
        send_cmd(CMD_BLINK_DIG, 6'd5, 8'd0, 7'sd0, 1'b1);
        send_cmd(CMD_BLINK_SCR, 6'd0, 8'd0, 7'sd0, 1'b1);
        send_cmd(CMD_CUR_ON, 6'd0, 8'd0, 7'sd0, 1'b0);
        send_cmd(CMD_CUR_DEC, 6'd0, 8'd0, 7'sd0, 1'b0);
        send_cmd(CMD_CUR_INC, 6'd0, 8'd0, 7'sd0, 1'b0);
        send_cmd(CMD_CUR_OFF, 6'd0, 8'd0, 7'sd0, 1'b0);
        send_cmd(CMD_ERASE, 6'd0, 8'd0, 7'sd0, 1'b0);
        send_cmd(4'd15, 6'd0, 8'd0, 7'sd0, 1'b0);
        send_cmd(CMD_TICK, 6'd0, 8'd0, 7'sd0, 1'b0);
        drain();

        send_idle_pct = 11;
        recv_idle_pct = 82;
        repeat (700) send_random();
        drain();
        set_brightness(3'd0);

        send_idle_pct = 82;
        recv_idle_pct = 11;
        repeat (650) send_random();
        drain();
        set_brightness(3'd2);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (650) send_random();
        drain();

        $display("covered %0d result beats, %0d with lit segments, brightness 5, 0 and 2",
                 results, lit);
        $display("with sender and receiver back-pressure swapped, then none");
        if (errors == 0 && pending == 0) begin
            $display("seven_segment_scan_controller_core_tb: clean");
        end else begin
            $display("seven_segment_scan_controller_core_tb: errors");
        end
        $finish;
    end

endmodule
